// ===== rtl/bwq_pkg.sv =====
// shared constants, codes and transfer types for the buffer wait queue arbiter
package bwq_pkg;

  // table geometry
  localparam int QUEUE_DEPTH = 8;
  localparam int BLOCK_BITS  = 16;
  localparam int FIELD_W     = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W     = BLOCK_BITS + 1;

  // operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  // wait kinds
  localparam logic KIND_ANY  = 1'b0;
  localparam logic KIND_THIS = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [FIELD_W-1:0] block_number;
    logic               wait_kind;
    logic               coin;
  } bwq_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] granted_block;
    logic               winner_kind;
    logic               found;
    logic               overflowed;
    logic               queue_empty;
  } bwq_out_t;

endpackage

// ===== rtl/buffer_wait_queue_arbiter.sv =====
// buffer wait queue arbiter: waiter table in ram, scanned one slot per cycle
// An add lands in the first empty slot, or in slot 0 when the table is full; a take
// finishes on the first pass or, with the favoured kind flipped, on a second pass.
// One command at a time; busy falls with the result strobe.
// Reset clears the per-slot valid bits and fill count at once; the receiver cannot stall.
module buffer_wait_queue_arbiter (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bwq_pkg::bwq_in_t  cmd,
  output logic              busy,
  output logic              done,
  output bwq_pkg::bwq_out_t result
);
  import bwq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE} state_t;

  state_t               state;
  logic                 op;
  logic [BLOCK_BITS-1:0] blk;
  logic                 wk;
  logic                 kind;
  logic                 second;
  logic [CNT_W-1:0]     issue_cnt;
  logic                 chk_valid;
  logic [IDX_W-1:0]     chk_idx;
  logic [IDX_W-1:0]     wr_idx;
  logic [ENTRY_W-1:0]   wr_data;
  logic                 wr_do;
  logic [BLOCK_BITS-1:0] grant;
  logic                 got;
  logic                 over;
  logic [QUEUE_DEPTH-1:0] valid;
  logic [CNT_W-1:0]     fill;
  logic [CNT_W-1:0]     fill_next;

  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENTRY_W-1:0]   rd_data;
  logic [ENTRY_W-1:0]   slot;
  logic [BLOCK_BITS-1:0] slot_blk;
  logic                 slot_kind;
  logic                 hit;
  logic                 last;
  logic [ENTRY_W-1:0]   new_entry;
  logic                 ram_we;

  assign busy = (state != S_IDLE);

  // read issue: one slot per cycle until the pass is fully issued
  assign rd_en   = (state == S_SCAN) && (issue_cnt < CNT_W'(QUEUE_DEPTH));
  assign rd_addr = issue_cnt[IDX_W-1:0];
  assign ram_we  = (state == S_WRITE) && wr_do;

  bwq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_idx),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // slot check on the data returned for chk_idx; never-written slots read empty
  always_comb begin
    slot      = valid[chk_idx] ? rd_data : '0;
    slot_blk  = slot[BLOCK_BITS-1:0];
    slot_kind = slot[BLOCK_BITS];
    if (op == OP_ADD) begin
      hit = (slot_blk == '0);
    end else begin
      hit = (slot_blk != '0) && (slot_kind == kind) &&
            ((kind == KIND_ANY) || (slot_blk == blk));
    end
    last      = (chk_idx == IDX_W'(QUEUE_DEPTH - 1));
    new_entry = (blk == '0) ? '0 : {wk, blk};
  end

  // occupancy count after the write-back
  always_comb begin
    fill_next = fill;
    if (op == OP_ADD) begin
      if (over) begin
        if (blk == '0) begin
          fill_next = fill - CNT_W'(1);
        end
      end else if (blk != '0) begin
        fill_next = fill + CNT_W'(1);
      end
    end else if (got) begin
      fill_next = fill - CNT_W'(1);
    end
  end

  // sequencer, scan pipeline and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      chk_valid <= 1'b0;
      valid     <= '0;
      fill      <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op        <= cmd.opcode;
            blk       <= BLOCK_BITS'(cmd.block_number);
            wk        <= cmd.wait_kind;
            kind      <= (cmd.opcode == OP_TAKE) ? cmd.coin : KIND_ANY;
            second    <= 1'b0;
            issue_cnt <= '0;
            chk_valid <= 1'b0;
            grant     <= '0;
            got       <= 1'b0;
            over      <= 1'b0;
            wr_do     <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            issue_cnt <= issue_cnt + CNT_W'(1);
            chk_idx   <= rd_addr;
            chk_valid <= 1'b1;
          end else begin
            chk_valid <= 1'b0;
          end
          if (chk_valid) begin
            if (hit) begin
              wr_idx  <= chk_idx;
              wr_do   <= 1'b1;
              wr_data <= (op == OP_ADD) ? new_entry : '0;
              grant   <= (op == OP_ADD) ? '0 : slot_blk;
              got     <= (op == OP_TAKE);
              state   <= S_WRITE;
            end else if (last) begin
              if (op == OP_ADD) begin
                // table full: overwrite slot 0
                over    <= 1'b1;
                wr_idx  <= '0;
                wr_data <= new_entry;
                wr_do   <= 1'b1;
                state   <= S_WRITE;
              end else if (!second) begin
                // favoured kind missed: flip and rescan from slot 0
                second    <= 1'b1;
                kind      <= ~kind;
                issue_cnt <= '0;
              end else begin
                wr_do <= 1'b0;
                state <= S_WRITE;
              end
            end
          end
        end
        S_WRITE: begin
          if (wr_do) begin
            valid[wr_idx] <= 1'b1;
          end
          fill                 <= fill_next;
          result.granted_block <= FIELD_W'(grant);
          result.winner_kind   <= kind;
          result.found         <= got;
          result.overflowed    <= over;
          result.queue_empty   <= (fill_next == '0);
          done                 <= 1'b1;
          state                <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks on the sequencer and result
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while a command is in progress");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> (result.granted_block != '0))
    else $error("take released a waiter with block zero");

  a_over_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.found && result.overflowed))
    else $error("overflow and release in one result");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy count beyond table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted command did not start a scan");

endmodule

// ===== rtl/bwq_ram.sv =====
// generic single write port, single read port ram with registered read
module bwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
